// ===== hw/rtl/wdl_pkg.sv =====
`default_nettype none

package wdl_pkg;

    localparam int MAX_ENTRIES   = 64;
    localparam int NAME_BYTES    = 8;
    localparam int BUILTIN_COUNT = 13;

    localparam int NAME_W  = 64;
    localparam int ENTRY_W = 16;
    localparam int SLOT_W  = 6;
    localparam int OP_W    = 4;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    localparam logic KIND_FIND   = 1'b0;
    localparam logic KIND_DEFINE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } wdl_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_end;
    } wdl_sts_t;

    // cut at first zero byte, then keep at most NAME_BYTES bytes
    function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] r;
        logic              alive;
        r     = '0;
        alive = 1'b1;
        for (int i = 0; i < NAME_W / 8; i++) begin
            if (v[8*i +: 8] == 8'h00 || i >= NAME_BYTES) begin
                alive = 1'b0;
            end
            if (alive) begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

    // packed seed names, first character in the low byte
    function automatic logic [NAME_W-1:0] builtin_name(input logic [IDX_W-1:0] idx);
        logic [NAME_W-1:0] raw;
        case (idx)
            IDX_W'(0):  raw = 64'h2B;          // +
            IDX_W'(1):  raw = 64'h2D;          // -
            IDX_W'(2):  raw = 64'h2A;          // *
            IDX_W'(3):  raw = 64'h2F;          // /
            IDX_W'(4):  raw = 64'h646F6D;      // mod
            IDX_W'(5):  raw = 64'h707564;      // dup
            IDX_W'(6):  raw = 64'h706F7264;    // drop
            IDX_W'(7):  raw = 64'h70617773;    // swap
            IDX_W'(8):  raw = 64'h7265766F;    // over
            IDX_W'(9):  raw = 64'h2E;          // .
            IDX_W'(10): raw = 64'h732E;        // .s
            IDX_W'(11): raw = 64'h7261656C63;  // clear
            IDX_W'(12): raw = 64'h3C;          // <
            default:    raw = '0;
        endcase
        return normalize_name(raw);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wdl_ctrl.sv =====
`default_nettype none

module wdl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire wdl_pkg::wdl_sts_t  sts,
    output wdl_pkg::wdl_cmd_t  cmd,
    output logic               busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.scan_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == S_SCAN);

endmodule

`default_nettype wire

// ===== hw/rtl/wdl_dpath.sv =====
`default_nettype none

module wdl_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire wdl_pkg::wdl_cmd_t            cmd,
    output wdl_pkg::wdl_sts_t                 sts,
    input  wire logic                         kind,
    input  wire logic [wdl_pkg::NAME_W-1:0]   name_chars,
    input  wire logic [wdl_pkg::ENTRY_W-1:0]  code_offset,
    output logic                              done,
    output logic [wdl_pkg::STAT_W-1:0]        status,
    output logic                              found,
    output logic [wdl_pkg::SLOT_W-1:0]        slot,
    output logic                              is_user,
    output logic [wdl_pkg::OP_W-1:0]          op_number,
    output logic [wdl_pkg::ENTRY_W-1:0]       entry_point
);

    localparam int IDX_W   = wdl_pkg::IDX_W;
    localparam int CNT_W   = wdl_pkg::CNT_W;
    localparam int NAME_W  = wdl_pkg::NAME_W;
    localparam int ENTRY_W = wdl_pkg::ENTRY_W;

    // user entries only; built-in slots are served by the constant table
    logic [NAME_W-1:0]  name_mem [wdl_pkg::MAX_ENTRIES];
    logic [ENTRY_W-1:0] ent_mem  [wdl_pkg::MAX_ENTRIES];

    logic [NAME_W-1:0]  rd_name_reg;
    logic [ENTRY_W-1:0] rd_ent_reg;

    logic               kind_reg;
    logic [NAME_W-1:0]  name_reg;
    logic [ENTRY_W-1:0] offset_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0]   tag_reg, tag_next;
    logic               tag_vld_reg, tag_vld_next;
    logic               done_reg, done_next;

    logic [wdl_pkg::STAT_W-1:0] status_reg, status_next;
    logic                       found_reg, found_next;
    logic [wdl_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                       user_reg, user_next;
    logic [wdl_pkg::OP_W-1:0]   op_reg, op_next;
    logic [ENTRY_W-1:0]         ent_reg, ent_next;

    logic [NAME_W-1:0] name_norm;
    logic [CNT_W-1:0]  rem_dec;
    logic [IDX_W-1:0]  rd_addr;
    logic              tag_builtin;
    logic [NAME_W-1:0] cmp_name;
    logic              hit;
    logic              wr_en;

    assign name_norm   = wdl_pkg::normalize_name(name_chars);
    assign rem_dec     = rem_reg - CNT_W'(1);
    assign rd_addr     = rem_dec[IDX_W-1:0];
    assign tag_builtin = (tag_reg < IDX_W'(wdl_pkg::BUILTIN_COUNT));
    assign cmp_name    = tag_builtin ? wdl_pkg::builtin_name(tag_reg) : rd_name_reg;
    assign hit         = tag_vld_reg && (cmp_name == name_reg);

    assign sts.hit      = hit;
    assign sts.scan_end = (rem_reg == '0) && !tag_vld_reg;

    // newest-first walk: one read issued per cycle, compared against the name in the cycle after
    always_comb
    begin
        rem_next     = rem_reg;
        tag_next     = tag_reg;
        tag_vld_next = tag_vld_reg;
        if (cmd.load)
        begin
            rem_next     = (name_norm != '0) ? count_reg : '0;
            tag_vld_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            if (rem_reg != '0)
            begin
                rem_next     = rem_dec;
                tag_next     = rd_addr;
                tag_vld_next = 1'b1;
            end
            else
            begin
                tag_vld_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        status_next = wdl_pkg::ST_OK;
        found_next  = 1'b0;
        slot_next   = '0;
        user_next   = 1'b0;
        op_next     = '0;
        ent_next    = '0;
        count_next  = count_reg;
        wr_en       = 1'b0;
        if (kind_reg == wdl_pkg::KIND_FIND)
        begin
            if (hit)
            begin
                found_next = 1'b1;
                slot_next  = wdl_pkg::SLOT_W'(tag_reg);
                user_next  = !tag_builtin;
                op_next    = tag_builtin ? wdl_pkg::OP_W'(tag_reg) : '0;
                ent_next   = tag_builtin ? '0 : rd_ent_reg;
            end
        end
        else
        begin
            if (name_reg == '0 || hit)
            begin
                status_next = wdl_pkg::ST_BAD;
            end
            else if (count_reg >= CNT_W'(wdl_pkg::MAX_ENTRIES))
            begin
                status_next = wdl_pkg::ST_FULL;
            end
            else
            begin
                slot_next  = wdl_pkg::SLOT_W'(count_reg);
                user_next  = 1'b1;
                ent_next   = offset_reg;
                count_next = count_reg + CNT_W'(1);
                wr_en      = cmd.finish;
            end
        end
        if (!cmd.finish)
        begin
            count_next = count_reg;
        end
    end

    assign done_next = cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CNT_W'(wdl_pkg::BUILTIN_COUNT);
            rem_reg     <= '0;
            tag_reg     <= '0;
            tag_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            tag_reg     <= tag_next;
            tag_vld_reg <= tag_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            name_reg   <= name_norm;
            offset_reg <= code_offset;
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            slot_reg   <= slot_next;
            user_reg   <= user_next;
            op_reg     <= op_next;
            ent_reg    <= ent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[count_reg[IDX_W-1:0]] <= name_reg;
            ent_mem[count_reg[IDX_W-1:0]]  <= offset_reg;
        end
        rd_name_reg <= name_mem[rd_addr];
        rd_ent_reg  <= ent_mem[rd_addr];
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign slot        = slot_reg;
    assign is_user     = user_reg;
    assign op_number   = op_reg;
    assign entry_point = ent_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(wdl_pkg::BUILTIN_COUNT) &&
        count_reg <= CNT_W'(wdl_pkg::MAX_ENTRIES))
        else $error("entry count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))) && $past(cmd.finish))
        else $error("entry count changed other than by one define");

    a_tag_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        tag_vld_reg |-> (CNT_W'(tag_reg) < count_reg))
        else $error("compare tag beyond the table");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (status_reg == wdl_pkg::ST_OK && kind_reg == wdl_pkg::KIND_FIND))
        else $error("found flagged on a non-find or failed transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/word_dictionary_lookup_define.sv =====
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// command  | start & !busy      | kind, name_chars, code_offset
// result   | done (1 cycle)     | status, found, slot, is_user, op_number, entry_point
//
// a transaction walks the table newest first, one entry per cycle through the single
// read port of the name memory; a miss walks every entry before done, a hit ends
// the walk early, and an empty name ends it without comparing any entry
// busy falls in the cycle that done is shown, so the next command can be taken then
// after reset the 13 built-in words are present at once; no clearing pass
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none

module word_dictionary_lookup_define (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         kind,
    input  wire logic [wdl_pkg::NAME_W-1:0]   name_chars,
    input  wire logic [wdl_pkg::ENTRY_W-1:0]  code_offset,
    output logic                              done,
    output logic [wdl_pkg::STAT_W-1:0]        status,
    output logic                              found,
    output logic [wdl_pkg::SLOT_W-1:0]        slot,
    output logic                              is_user,
    output logic [wdl_pkg::OP_W-1:0]          op_number,
    output logic [wdl_pkg::ENTRY_W-1:0]       entry_point
);

    wdl_pkg::wdl_cmd_t cmd;
    wdl_pkg::wdl_sts_t sts;

    wdl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    wdl_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .name_chars  (name_chars),
        .code_offset (code_offset),
        .done        (done),
        .status      (status),
        .found       (found),
        .slot        (slot),
        .is_user     (is_user),
        .op_number   (op_number),
        .entry_point (entry_point)
    );

endmodule

`default_nettype wire
